### hdl/mandelbrot_escape_iteration_defines.svh
// Assertion macros shared by the escape iteration RTL.
`ifndef MANDELBROT_ESCAPE_ITERATION_DEFINES_SVH
`define MANDELBROT_ESCAPE_ITERATION_DEFINES_SVH

// Checks a consequence in the same cycle as its cause.
`define MEI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its cause.
`define MEI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mei_pkg.sv
// Package of fixed-point constants and saturating helpers for the escape iteration.
`default_nettype none

package mei_pkg;

    localparam int IN_W      = 32;
    localparam int Q_W       = 64;
    localparam int Q_FRAC    = 56;
    localparam int CFG_W     = 16;
    localparam int RESULT_W  = 16;
    localparam int RING_LEN  = 10;
    localparam int TAG_W     = $clog2(RING_LEN) + 1;

    localparam logic [CFG_W-1:0]      MAX_ITER_RESET = 16'd256;
    localparam logic signed [Q_W-1:0] Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [Q_W-1:0] FOUR_Q = 64'sh0400_0000_0000_0000;

    function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1])
        begin
            return s[Q_W] ? Q_MIN : Q_MAX;
        end
        return $signed(s[Q_W-1:0]);
    endfunction

    function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic [Q_W:0] s;
        s = {a[Q_W-1], a} - {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1])
        begin
            return s[Q_W] ? Q_MIN : Q_MAX;
        end
        return $signed(s[Q_W-1:0]);
    endfunction

    // Cuts an unsigned 128-bit product magnitude toward zero to Q8.56, applies the sign
    // and saturates. With dbl set the product is doubled, which is one place less shift.
    function automatic logic signed [Q_W-1:0] fx_cut(input logic [2*Q_W-1:0] p,
                                                     input logic neg,
                                                     input logic dbl);
        logic           ovf;
        logic [Q_W-1:0] m;
        ovf = dbl ? (|p[2*Q_W-1:Q_W+Q_FRAC-1]) : (|p[2*Q_W-1:Q_W+Q_FRAC]);
        m   = dbl ? p[Q_W+Q_FRAC-2:Q_FRAC-1] : p[Q_W+Q_FRAC-1:Q_FRAC];
        if (ovf)
        begin
            return neg ? Q_MIN : Q_MAX;
        end
        if (neg)
        begin
            return m[Q_W-1] ? Q_MIN : $signed(Q_W'(-m));
        end
        return m[Q_W-1] ? Q_MAX : $signed(m);
    endfunction

endpackage

`default_nettype wire

### hdl/mei_mul.sv
// Three-stage signed 64 by 64 multiplier giving the product magnitude and its sign.
`default_nettype none

module mei_mul
(
    input  wire logic                           clk,
    input  wire logic signed [mei_pkg::Q_W-1:0] a,
    input  wire logic signed [mei_pkg::Q_W-1:0] b,
    output logic [2*mei_pkg::Q_W-1:0]           prod,
    output logic                                neg
);
    import mei_pkg::*;

    localparam int HALF_W = Q_W / 2;

    logic [Q_W-1:0]   mag_a_reg;
    logic [Q_W-1:0]   mag_b_reg;
    logic             neg1_reg;
    logic [Q_W-1:0]   pll_reg;
    logic [Q_W-1:0]   plh_reg;
    logic [Q_W-1:0]   phl_reg;
    logic [Q_W-1:0]   phh_reg;
    logic             neg2_reg;
    logic [2*Q_W-1:0] prod_reg;
    logic             neg3_reg;

    always_ff @(posedge clk)
    begin
        mag_a_reg <= a[Q_W-1] ? Q_W'(-a) : a;
        mag_b_reg <= b[Q_W-1] ? Q_W'(-b) : b;
        neg1_reg  <= a[Q_W-1] ^ b[Q_W-1];

        pll_reg  <= mag_a_reg[HALF_W-1:0]   * mag_b_reg[HALF_W-1:0];
        plh_reg  <= mag_a_reg[HALF_W-1:0]   * mag_b_reg[Q_W-1:HALF_W];
        phl_reg  <= mag_a_reg[Q_W-1:HALF_W] * mag_b_reg[HALF_W-1:0];
        phh_reg  <= mag_a_reg[Q_W-1:HALF_W] * mag_b_reg[Q_W-1:HALF_W];
        neg2_reg <= neg1_reg;

        prod_reg <= {{Q_W{1'b0}}, pll_reg}
                  + {{HALF_W{1'b0}}, plh_reg, {HALF_W{1'b0}}}
                  + {{HALF_W{1'b0}}, phl_reg, {HALF_W{1'b0}}}
                  + {phh_reg, {Q_W{1'b0}}};
        neg3_reg <= neg2_reg;
    end

    assign prod = prod_reg;
    assign neg  = neg3_reg;

endmodule

`default_nettype wire

### hdl/mandelbrot_escape_iteration.sv
// Mandelbrot escape-time engine: a ten-stage ring that iterates up to ten points at once.
// One round of z = z^2 + c is one lap of the ring, its length set by the chained multipliers.
// A point that stops after n rounds (n is 0 when the limit is 0) gives its word once its last
// lap is done, it is the oldest and the output register is free.
// With the ring full a new point is taken only as an old one retires; words leave in order.
// Reset empties the ring and output register and sets max_iterations to 256.
`default_nettype none
`include "mandelbrot_escape_iteration_defines.svh"

module mandelbrot_escape_iteration
#(
    parameter int INPUT_FRAC_BITS = 28,
    parameter int COUNT_WIDTH     = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wen,
    input  wire logic [mei_pkg::CFG_W-1:0]           cfg_wdata,
    input  wire logic                                point_valid,
    output logic                                     point_stall,
    input  wire logic signed [mei_pkg::IN_W-1:0]     const_re,
    input  wire logic signed [mei_pkg::IN_W-1:0]     const_im,
    input  wire logic signed [mei_pkg::IN_W-1:0]     start_re,
    input  wire logic signed [mei_pkg::IN_W-1:0]     start_im,
    input  wire logic signed [mei_pkg::IN_W-1:0]     start_re_squared,
    input  wire logic signed [mei_pkg::IN_W-1:0]     start_im_squared,
    output logic                                     esc_valid,
    input  wire logic                                esc_stall,
    output logic [mei_pkg::RESULT_W-1:0]             escape_count
);
    import mei_pkg::*;

    localparam int SH     = Q_FRAC - INPUT_FRAC_BITS;
    localparam int WIDE_W = (IN_W + SH > Q_W) ? IN_W + SH : Q_W + 1;
    localparam int LAST   = RING_LEN - 1;

    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic [TAG_W-1:0]        tag;
        logic [COUNT_WIDTH-1:0]  count;
        logic [RESULT_W-1:0]     result;
        logic signed [Q_W-1:0]   c_re;
        logic signed [Q_W-1:0]   c_im;
        logic signed [Q_W-1:0]   re;
        logic signed [Q_W-1:0]   im;
        logic signed [Q_W-1:0]   re_sq;
        logic signed [Q_W-1:0]   im_sq;
    } slot_t;

    function automatic logic signed [Q_W-1:0] to_q(input logic signed [IN_W-1:0] x);
        logic signed [WIDE_W-1:0] wide;
        wide = WIDE_W'(x) <<< SH;
        if ((&wide[WIDE_W-1:Q_W-1]) || !(|wide[WIDE_W-1:Q_W-1]))
        begin
            return $signed(wide[Q_W-1:0]);
        end
        return wide[WIDE_W-1] ? Q_MIN : Q_MAX;
    endfunction

    slot_t                  st_reg  [RING_LEN];
    slot_t                  st_next [RING_LEN];
    slot_t                  loop_slot;
    logic [CFG_W-1:0]       max_iterations_reg;
    logic [TAG_W-1:0]       tag_in_reg;
    logic [TAG_W-1:0]       tag_out_reg;
    logic                   esc_valid_reg;
    logic [RESULT_W-1:0]    escape_count_reg;
    logic [COUNT_WIDTH-1:0] limit;
    logic [COUNT_WIDTH-1:0] round_n;
    logic                   escaped;
    logic                   retire;
    logic                   entry_free;
    logic                   accept;
    logic [RING_LEN-1:0]    vld_vec;
    logic [2*Q_W-1:0]       mul_a_prod;
    logic [2*Q_W-1:0]       mul_b_prod;
    logic [2*Q_W-1:0]       mul_c_prod;
    logic                   mul_a_neg;
    logic                   mul_b_neg;
    logic                   mul_c_neg;

    // Twice re times im for the new imaginary part.
    mei_mul u_mul_a
    (
        .clk  (clk),
        .a    (st_reg[0].re),
        .b    (st_reg[0].im),
        .prod (mul_a_prod),
        .neg  (mul_a_neg)
    );

    // Square of the new real part.
    mei_mul u_mul_b
    (
        .clk  (clk),
        .a    (st_reg[2].re),
        .b    (st_reg[2].re),
        .prod (mul_b_prod),
        .neg  (mul_b_neg)
    );

    // Square of the new imaginary part.
    mei_mul u_mul_c
    (
        .clk  (clk),
        .a    (st_reg[5].im),
        .b    (st_reg[5].im),
        .prod (mul_c_prod),
        .neg  (mul_c_neg)
    );

    assign limit = COUNT_WIDTH'(max_iterations_reg);

    // Fields are reused along the ring once their old value is no longer needed.
    always_comb
    begin
        for (int i = 1; i < RING_LEN; i++)
        begin
            st_next[i] = st_reg[i-1];
        end
        st_next[1].re_sq = sat_sub(st_reg[0].re_sq, st_reg[0].im_sq);
        st_next[2].re    = sat_add(st_reg[1].re_sq, st_reg[1].c_re);
        st_next[4].im    = fx_cut(mul_a_prod, mul_a_neg, 1'b1);
        st_next[5].im    = sat_add(st_reg[4].im, st_reg[4].c_im);
        st_next[6].re_sq = fx_cut(mul_b_prod, mul_b_neg, 1'b0);
        st_next[9].im_sq = fx_cut(mul_c_prod, mul_c_neg, 1'b0);

        round_n    = COUNT_WIDTH'(st_reg[LAST].count + 1'b1);
        escaped    = sat_add(st_reg[LAST].im_sq, st_reg[LAST].re_sq) > FOUR_Q;
        retire     = st_reg[LAST].valid && st_reg[LAST].done
                     && (st_reg[LAST].tag == tag_out_reg) && (!esc_valid_reg || !esc_stall);
        entry_free = !st_reg[LAST].valid || retire;
        accept     = point_valid && entry_free;

        loop_slot = st_reg[LAST];
        if (st_reg[LAST].valid && !st_reg[LAST].done)
        begin
            loop_slot.count = round_n;
            if (escaped)
            begin
                loop_slot.done   = 1'b1;
                loop_slot.result = RESULT_W'(round_n);
            end
            else if (round_n == limit)
            begin
                loop_slot.done   = 1'b1;
                loop_slot.result = '0;
            end
        end
        if (retire)
        begin
            loop_slot.valid = 1'b0;
        end

        if (accept)
        begin
            st_next[0].valid  = 1'b1;
            st_next[0].done   = (limit == '0);
            st_next[0].tag    = tag_in_reg;
            st_next[0].count  = '0;
            st_next[0].result = '0;
            st_next[0].c_re   = to_q(const_re);
            st_next[0].c_im   = to_q(const_im);
            st_next[0].re     = to_q(start_re);
            st_next[0].im     = to_q(start_im);
            st_next[0].re_sq  = to_q(start_re_squared);
            st_next[0].im_sq  = to_q(start_im_squared);
        end
        else
        begin
            st_next[0] = loop_slot;
        end

        for (int i = 0; i < RING_LEN; i++)
        begin
            vld_vec[i] = st_reg[i].valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_LEN; i++)
            begin
                st_reg[i] <= '0;
            end
            max_iterations_reg <= MAX_ITER_RESET;
            tag_in_reg         <= '0;
            tag_out_reg        <= '0;
            esc_valid_reg      <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < RING_LEN; i++)
            begin
                st_reg[i] <= st_next[i];
            end
            if (cfg_wen)
            begin
                max_iterations_reg <= cfg_wdata;
            end
            if (accept)
            begin
                tag_in_reg <= TAG_W'(tag_in_reg + 1'b1);
            end
            if (retire)
            begin
                tag_out_reg <= TAG_W'(tag_out_reg + 1'b1);
            end
            if (retire)
            begin
                esc_valid_reg <= 1'b1;
            end
            else if (!esc_stall)
            begin
                esc_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            escape_count_reg <= st_reg[LAST].result;
        end
    end

    assign point_stall  = !entry_free;
    assign esc_valid    = esc_valid_reg;
    assign escape_count = escape_count_reg;

    `MEI_ASSERT_NEXT(a_accept_lands, accept, st_reg[0].valid,
                     "An accepted word did not enter the ring.")
    `MEI_ASSERT_SAME(a_occupancy, 1'b1,
                     TAG_W'($countones(vld_vec)) == TAG_W'(tag_in_reg - tag_out_reg),
                     "Ring occupancy disagrees with the tag counters.")
    `MEI_ASSERT_NEXT(a_done_kept, st_reg[LAST].valid && st_reg[LAST].done && !retire,
                     st_reg[0].valid && st_reg[0].done,
                     "A finished point was lost or restarted in the ring.")
    `MEI_ASSERT_NEXT(a_round_step, st_reg[LAST].valid && !st_reg[LAST].done && !accept,
                     st_reg[0].count == COUNT_WIDTH'($past(st_reg[LAST].count) + 1'b1),
                     "The round count did not advance by one per lap.")

endmodule

`default_nettype wire
